>>> src/arpc_pkg.sv
package arpc_pkg;

	// Default size of the address table.
	localparam int TABLE_ENTRIES_DEF = 16;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RESEND = 8'd3;

	// Configuration reset values.
	localparam logic [7:0] WAIT_TICKS_RST = 8'd4;
	localparam logic [3:0] MAX_RESEND_RST = 4'd3;

	// Input item functions.
	localparam logic [1:0] FUNC_RESOLVE = 2'd0;
	localparam logic [1:0] FUNC_ARP_REQ = 2'd1;
	localparam logic [1:0] FUNC_ARP_RPL = 2'd2;
	localparam logic [1:0] FUNC_TICK    = 2'd3;

	// Result kinds.
	localparam logic [2:0] KIND_RESOLVED = 3'd0;
	localparam logic [2:0] KIND_SEND_REQ = 3'd1;
	localparam logic [2:0] KIND_SEND_RPL = 3'd2;
	localparam logic [2:0] KIND_FAILED   = 3'd3;
	localparam logic [2:0] KIND_BUSY     = 3'd4;

	// ARP opcodes.
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_REQUEST = 2'd1;
	localparam logic [1:0] OP_REPLY   = 2'd2;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] lookup_ip;
		logic [31:0] peer_ip;
		logic [47:0] peer_mac;
		logic [31:0] asked_ip;
	} arpc_req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [47:0] resolved_mac;
		logic [47:0] frame_dest_mac;
		logic [1:0]  arp_op;
		logic [31:0] arp_sender_ip;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_target_ip;
		logic [47:0] arp_target_mac;
	} arpc_rsp_t;

	typedef struct packed {
		logic [31:0] own_ip;
		logic [47:0] own_mac;
		logic [7:0]  wait_ticks;
		logic [3:0]  max_resend;
	} arpc_cfg_t;

	// Table write request; the address is the table's lookup key.
	typedef struct packed {
		logic        en;
		logic [47:0] mac;
	} arpc_tbl_wr_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] mac;
	} arpc_tbl_rsp_t;

endpackage

>>> src/arpc_if.sv
interface arpc_req_if;
	logic                 valid;
	logic                 ready;
	arpc_pkg::arpc_req_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arpc_rsp_if;
	logic                 valid;
	logic                 ready;
	arpc_pkg::arpc_rsp_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arpc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [arpc_pkg::CFG_IDX_W-1:0]      index;
	logic [arpc_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/arpc_cfg.sv
module arpc_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	arpc_cfg_if.sink             cfg,
	output arpc_pkg::arpc_cfg_t  regs
);

	arpc_pkg::arpc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.own_ip     <= '0;
			regs_q.own_mac    <= '0;
			regs_q.wait_ticks <= arpc_pkg::WAIT_TICKS_RST;
			regs_q.max_resend <= arpc_pkg::MAX_RESEND_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				arpc_pkg::REG_OWN_IP:     regs_q.own_ip     <= cfg.data[31:0];
				arpc_pkg::REG_OWN_MAC:    regs_q.own_mac    <= cfg.data[47:0];
				arpc_pkg::REG_WAIT_TICKS: regs_q.wait_ticks <= cfg.data[7:0];
				arpc_pkg::REG_MAX_RESEND: regs_q.max_resend <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/arpc_table.sv
module arpc_table #(
	parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [31:0]             key,
	input  arpc_pkg::arpc_tbl_wr_t  wr,
	output arpc_pkg::arpc_tbl_rsp_t rsp
);

	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0]              ip_q  [TABLE_ENTRIES];
	logic [47:0]              mac_q [TABLE_ENTRIES];
	logic [IdxW-1:0]          ptr_q;

	logic [TABLE_ENTRIES-1:0] match;
	logic [IdxW-1:0]          hit_idx;
	logic [IdxW-1:0]          free_idx;
	logic                     any_free;
	logic [IdxW-1:0]          wr_idx;
	logic                     full;

	// Walking down from the top leaves the lowest matching or free slot.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (ip_q[i] == key);
			if (match[i])
				hit_idx = IdxW'(i);
			if (!valid_q[i])
				free_idx = IdxW'(i);
		end
	end

	assign any_free = ~&valid_q;
	assign full     = !(|match) && !any_free;

	always_comb begin
		if (|match)
			wr_idx = hit_idx;
		else if (any_free)
			wr_idx = free_idx;
		else
			wr_idx = ptr_q;
	end

	assign rsp.hit = |match;
	assign rsp.mac = mac_q[hit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (wr.en) begin
			valid_q[wr_idx] <= 1'b1;
			if (full) begin
				if (ptr_q == IdxW'(TABLE_ENTRIES - 1))
					ptr_q <= '0;
				else
					ptr_q <= ptr_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ip_q[wr_idx]  <= key;
			mac_q[wr_idx] <= wr.mac;
		end
	end

`ifndef SYNTHESIS
	// Entries are never invalidated once written.
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("table entry lost its valid bit");

	// The replacement pointer only moves when every slot was in use.
	a_ptr_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != $past(ptr_q)) |-> $past(&valid_q))
		else $error("replacement pointer moved with a free slot");

	// The replacement pointer always names a real slot.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q <= IdxW'(TABLE_ENTRIES - 1)))
		else $error("replacement pointer out of range");
`endif

endmodule

>>> src/arp_cache_resolver.sv
// Channel  Modport  Payload        Meaning
// query    sink     arpc_req_t     resolve, received request or reply, time tick
// result   source   arpc_rsp_t     resolved MAC, frame to send, failure or busy
// cfg      sink     index, data    own_ip, own_mac, wait_ticks, max_resend
//
// An item waits in the input register, is decided there against the table and
// the pending resolve, and then moves into the result register; a new item can
// be taken in every cycle while the result register is free or being emptied.
// The table compare and update set the rate of one item a cycle unless results stall.
// Reset clears the table's valid bits, the pending resolve and the registers.
// A result that is not taken holds the input register; items without a result
// still wait for the result register to drain before they leave.
module arp_cache_resolver #(
	parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	arpc_req_if.sink   query,
	arpc_rsp_if.source result,
	arpc_cfg_if.sink   cfg
);

	arpc_pkg::arpc_cfg_t     regs;
	arpc_pkg::arpc_tbl_wr_t  tbl_wr;
	arpc_pkg::arpc_tbl_rsp_t tbl_rsp;
	logic [31:0]             tbl_key;

	// Input register.
	logic                 valid_s1;
	arpc_pkg::arpc_req_t  req_s1;

	// Result register.
	logic                 rsp_valid_q;
	arpc_pkg::arpc_rsp_t  rsp_q;

	// Pending resolve.
	logic        pending_q;
	logic [31:0] pending_ip_q;
	logic [7:0]  wait_count_q;
	logic [4:0]  retry_count_q;

	logic        pending_d;
	logic [31:0] pending_ip_d;
	logic [7:0]  wait_count_d;
	logic [4:0]  retry_count_d;

	logic                 advance;
	logic                 has_rsp;
	arpc_pkg::arpc_rsp_t  rsp_d;
	logic [8:0]           wait_sum;
	logic [4:0]           retry_inc;

	// Builds the broadcast request frame for an address.
	function automatic arpc_pkg::arpc_rsp_t request_frame(
		input arpc_pkg::arpc_cfg_t r,
		input logic [31:0]         ip
	);
		arpc_pkg::arpc_rsp_t f;
		f                = '0;
		f.result_kind    = arpc_pkg::KIND_SEND_REQ;
		f.frame_dest_mac = arpc_pkg::BCAST_MAC;
		f.arp_op         = arpc_pkg::OP_REQUEST;
		f.arp_sender_ip  = r.own_ip;
		f.arp_sender_mac = r.own_mac;
		f.arp_target_ip  = ip;
		return f;
	endfunction

	arpc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Resolves look up the requested address, replies the sender's address.
	assign tbl_key = (req_s1.func == arpc_pkg::FUNC_RESOLVE) ? req_s1.lookup_ip
		: req_s1.peer_ip;
	assign tbl_wr.en  = advance && (req_s1.func == arpc_pkg::FUNC_ARP_RPL);
	assign tbl_wr.mac = req_s1.peer_mac;

	arpc_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (tbl_key),
		.wr     (tbl_wr),
		.rsp    (tbl_rsp)
	);

	// The item in the input register leaves when the result register is free
	// or being emptied in the same cycle.
	assign advance     = valid_s1 && (!rsp_valid_q || result.ready);
	assign query.ready = !valid_s1 || advance;

	assign result.valid = rsp_valid_q;
	assign result.data  = rsp_q;

	assign wait_sum  = {1'b0, wait_count_q} + 9'd1;
	assign retry_inc = retry_count_q + 5'd1;

	always_comb begin
		has_rsp       = 1'b0;
		rsp_d         = '0;
		pending_d     = pending_q;
		pending_ip_d  = pending_ip_q;
		wait_count_d  = wait_count_q;
		retry_count_d = retry_count_q;
		case (req_s1.func)
			arpc_pkg::FUNC_RESOLVE: begin
				has_rsp = 1'b1;
				if (tbl_rsp.hit) begin
					rsp_d.result_kind  = arpc_pkg::KIND_RESOLVED;
					rsp_d.resolved_mac = tbl_rsp.mac;
				end else if (pending_q) begin
					// Only one resolve may wait for an answer at a time.
					rsp_d.result_kind = arpc_pkg::KIND_BUSY;
				end else begin
					pending_d     = 1'b1;
					pending_ip_d  = req_s1.lookup_ip;
					wait_count_d  = '0;
					retry_count_d = '0;
					rsp_d         = request_frame(regs, req_s1.lookup_ip);
				end
			end
			arpc_pkg::FUNC_ARP_REQ: begin
				if (req_s1.asked_ip == regs.own_ip) begin
					has_rsp              = 1'b1;
					rsp_d.result_kind    = arpc_pkg::KIND_SEND_RPL;
					rsp_d.frame_dest_mac = req_s1.peer_mac;
					rsp_d.arp_op         = arpc_pkg::OP_REPLY;
					rsp_d.arp_sender_ip  = req_s1.asked_ip;
					rsp_d.arp_sender_mac = regs.own_mac;
					rsp_d.arp_target_ip  = req_s1.peer_ip;
					rsp_d.arp_target_mac = req_s1.peer_mac;
				end
			end
			arpc_pkg::FUNC_ARP_RPL: begin
				// The table is written in any case; a reply for the pending
				// address also finishes that resolve right away.
				if (pending_q && (pending_ip_q == req_s1.peer_ip)) begin
					has_rsp            = 1'b1;
					rsp_d.result_kind  = arpc_pkg::KIND_RESOLVED;
					rsp_d.resolved_mac = req_s1.peer_mac;
					pending_d          = 1'b0;
					wait_count_d       = '0;
					retry_count_d      = '0;
				end
			end
			default: begin
				// Time tick: only counts while a resolve is pending.
				if (pending_q) begin
					if (wait_sum > {1'b0, regs.wait_ticks}) begin
						wait_count_d = '0;
						has_rsp      = 1'b1;
						if (retry_inc > {1'b0, regs.max_resend}) begin
							pending_d         = 1'b0;
							retry_count_d     = '0;
							rsp_d.result_kind = arpc_pkg::KIND_FAILED;
						end else begin
							retry_count_d = retry_inc;
							rsp_d         = request_frame(regs, pending_ip_q);
						end
					end else begin
						wait_count_d = wait_sum[7:0];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			rsp_valid_q   <= 1'b0;
			pending_q     <= 1'b0;
			pending_ip_q  <= '0;
			wait_count_q  <= '0;
			retry_count_q <= '0;
		end else begin
			if (query.ready)
				valid_s1 <= query.valid;
			if (advance) begin
				rsp_valid_q   <= has_rsp;
				pending_q     <= pending_d;
				pending_ip_q  <= pending_ip_d;
				wait_count_q  <= wait_count_d;
				retry_count_q <= retry_count_d;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query.valid && query.ready)
			req_s1 <= query.data;
		if (advance && has_rsp)
			rsp_q <= rsp_d;
	end

`ifndef SYNTHESIS
	// With no resolve pending, both timers rest at zero.
	a_idle_timers: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (wait_count_q == '0) && (retry_count_q == '0))
		else $error("timers running without a pending resolve");

	// A request frame always goes to the broadcast address.
	a_req_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.result_kind == arpc_pkg::KIND_SEND_REQ)) |->
		(rsp_q.arp_op == arpc_pkg::OP_REQUEST) &&
		(rsp_q.frame_dest_mac == arpc_pkg::BCAST_MAC))
		else $error("malformed request frame");

	// A resolve only starts a request when none is pending.
	a_single_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pending_q && (req_s1.func == arpc_pkg::FUNC_RESOLVE)) |=>
		$stable(pending_ip_q))
		else $error("pending address replaced while pending");
`endif

endmodule
